FILE: rtl/core/cwdec_pkg.sv
// cwdec_pkg: opcode table, type codes, status codes and the result record
// of the bytecode instruction decoder. No dependencies.
`default_nettype none

package cwdec_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_BADTYPE = 2'd2;

  localparam logic [1:0] T_NONE = 2'd0;
  localparam logic [1:0] T_REG  = 2'd1;
  localparam logic [1:0] T_DIR  = 2'd2;
  localparam logic [1:0] T_IND  = 2'd3;

  localparam logic [2:0] A_REG = 3'b001;
  localparam logic [2:0] A_DIR = 3'b010;
  localparam logic [2:0] A_IND = 3'b100;
  localparam logic [2:0] A_RDI = A_REG | A_DIR | A_IND;

  localparam logic [7:0] OPC_MAX     = 8'h10;
  localparam logic [7:0] ENC_IMPLIED = 8'h80;

  typedef struct packed {
    logic [1:0]      count;
    logic            has_enc;
    logic            small_dir;
    logic [2:0][2:0] allow;
  } op_desc_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        opcode;
    logic [1:0]        param_count;
    logic [1:0]        type_a;
    logic [1:0]        type_b;
    logic [1:0]        type_c;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic [3:0]        size;
  } res_t;

  function automatic op_desc_t mk_desc(input logic [1:0] count, input logic has_enc,
                                       input logic small_dir, input logic [2:0] a0,
                                       input logic [2:0] a1, input logic [2:0] a2);
    op_desc_t d;
    d.count     = count;
    d.has_enc   = has_enc;
    d.small_dir = small_dir;
    d.allow     = {a2, a1, a0};
    return d;
  endfunction

  function automatic op_desc_t op_desc(input logic [4:0] op);
    op_desc_t d;
    case (op)
      5'd1:    d = mk_desc(2'd1, 1'b0, 1'b0, A_DIR, 3'b000, 3'b000);
      5'd2:    d = mk_desc(2'd2, 1'b1, 1'b0, A_DIR | A_IND, A_REG, 3'b000);
      5'd3:    d = mk_desc(2'd2, 1'b1, 1'b0, A_REG, A_IND | A_REG, 3'b000);
      5'd4:    d = mk_desc(2'd3, 1'b1, 1'b0, A_REG, A_REG, A_REG);
      5'd5:    d = mk_desc(2'd3, 1'b1, 1'b0, A_REG, A_REG, A_REG);
      5'd6:    d = mk_desc(2'd3, 1'b1, 1'b0, A_RDI, A_RDI, A_REG);
      5'd7:    d = mk_desc(2'd3, 1'b1, 1'b0, A_RDI, A_RDI, A_REG);
      5'd8:    d = mk_desc(2'd3, 1'b1, 1'b0, A_RDI, A_RDI, A_REG);
      5'd9:    d = mk_desc(2'd1, 1'b0, 1'b1, A_DIR, 3'b000, 3'b000);
      5'd10:   d = mk_desc(2'd3, 1'b1, 1'b1, A_RDI, A_DIR | A_REG, A_REG);
      5'd11:   d = mk_desc(2'd3, 1'b1, 1'b1, A_REG, A_RDI, A_DIR | A_REG);
      5'd12:   d = mk_desc(2'd1, 1'b0, 1'b1, A_DIR, 3'b000, 3'b000);
      5'd13:   d = mk_desc(2'd2, 1'b1, 1'b0, A_DIR | A_IND, A_REG, 3'b000);
      5'd14:   d = mk_desc(2'd3, 1'b1, 1'b1, A_RDI, A_DIR | A_REG, A_REG);
      5'd15:   d = mk_desc(2'd1, 1'b0, 1'b1, A_DIR, 3'b000, 3'b000);
      5'd16:   d = mk_desc(2'd1, 1'b1, 1'b0, A_REG, 3'b000, 3'b000);
      default: d = mk_desc(2'd0, 1'b0, 1'b0, 3'b000, 3'b000, 3'b000);
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cwdec_in_if.sv
// cwdec_in_if: input byte channel of the instruction decoder.
// Standalone, no dependencies.
`default_nettype none

interface cwdec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink (input valid, input data_byte, input restart, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/cwdec_out_if.sv
// cwdec_out_if: decoded instruction channel of the instruction decoder.
// Standalone, no dependencies.
`default_nettype none

interface cwdec_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [7:0]         opcode;
  logic [1:0]         param_count;
  logic [1:0]         type_a;
  logic [1:0]         type_b;
  logic [1:0]         type_c;
  logic signed [31:0] value_a;
  logic signed [31:0] value_b;
  logic signed [31:0] value_c;
  logic [3:0]         size;

  modport source (output valid, output status, output opcode, output param_count,
                  output type_a, output type_b, output type_c, output value_a,
                  output value_b, output value_c, output size, input ready);
  modport sink (input valid, input status, input opcode, input param_count,
                input type_a, input type_b, input type_c, input value_a,
                input value_b, input value_c, input size, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/corewar_instruction_decoder.sv
// corewar_instruction_decoder: top level, result register and skid stage.
// Depends on cwdec_pkg, cwdec_in_if, cwdec_out_if and cwdec_core.
//
// Usage:
//   in_ch carries one bytecode byte per beat (data_byte, restart); a beat
//   is taken when valid and ready are both high. restart drops any partial
//   instruction and takes the byte as an opcode.
//   out_ch carries one decoded instruction per beat: status, opcode,
//   param_count, the three types and values, and size in bytes.
//   Throughput: one byte per cycle while in_ch.ready is high; the decode state updates
//   in the accepting cycle and the result, if any, is registered.
//   Result: registered at the edge that takes the last byte of the
//   instruction (or the failing byte), into the result register if it is
//   empty or being emptied, else into the skid stage.
//   Stall: a result register plus a one-entry skid stage; in_ch.ready drops
//   only while the skid stage holds a result, so input keeps flowing while
//   one result waits.
//   Reset: rst_n low at a clock edge empties both stages and returns the
//   decoder to awaiting an opcode.
`default_nettype none

module corewar_instruction_decoder import cwdec_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  cwdec_in_if.sink     in_ch,
  cwdec_out_if.source  out_ch
);

  logic accept, pop, res_valid;
  res_t res;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_res_r, out_res_nxt;
  res_t skid_res_r, skid_res_nxt;

  assign in_ch.ready = !skid_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = out_valid_r && out_ch.ready;

  cwdec_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_ch.data_byte),
    .restart   (in_ch.restart),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || pop) begin
        out_res_nxt   = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_res_nxt   = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.opcode      = out_res_r.opcode;
  assign out_ch.param_count = out_res_r.param_count;
  assign out_ch.type_a      = out_res_r.type_a;
  assign out_ch.type_b      = out_res_r.type_b;
  assign out_ch.type_c      = out_res_r.type_c;
  assign out_ch.value_a     = out_res_r.value_a;
  assign out_ch.value_b     = out_res_r.value_b;
  assign out_ch.value_c     = out_res_r.value_c;
  assign out_ch.size        = out_res_r.size;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a beat while the result register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ch.ready) |=> (skid_valid_r && $stable(skid_res_r)))
    else $error("skid beat lost or changed during stall");

  a_overflow_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && out_valid_r && !out_ch.ready) |=> skid_valid_r)
    else $error("result produced during stall was not parked");

  a_unknown_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_UNKNOWN)
      |-> (out_ch.size == 4'd1 && out_ch.param_count == 2'd0))
    else $error("unknown opcode result has wrong size or count");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/cwdec_core.sv
// cwdec_core: per-byte decode state and result formation.
// Depends on cwdec_pkg.
`default_nettype none

module cwdec_core import cwdec_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       restart,
  output logic       res_valid,
  output res_t       res
);

  typedef enum logic [2:0] {
    PH_OPC = 3'b001,
    PH_ENC = 3'b010,
    PH_PAR = 3'b100
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [4:0]       held_r, held_nxt;
  logic [7:0]       enc_r, enc_nxt;
  logic [1:0]       pidx_r, pidx_nxt;
  logic [2:0]       left_r, left_nxt;
  logic [2:0][31:0] vals_r, vals_nxt;
  logic [2:0][1:0]  types_r, types_nxt;
  logic [3:0]       bcnt_r, bcnt_nxt;

  function automatic logic [1:0] type_of(input logic [7:0] enc, input logic [1:0] idx);
    logic [1:0] t;
    case (idx)
      2'd0:    t = enc[7:6];
      2'd1:    t = enc[5:4];
      default: t = enc[3:2];
    endcase
    return t;
  endfunction

  function automatic logic [2:0] param_len(input logic [1:0] t, input logic small_dir);
    logic [2:0] n;
    if (t == T_REG) begin
      n = 3'd1;
    end else if (t == T_IND) begin
      n = 3'd2;
    end else begin
      n = small_dir ? 3'd2 : 3'd4;
    end
    return n;
  endfunction

  function automatic logic [2:0] type_bit(input logic [1:0] t);
    logic [2:0] b;
    unique case (t)
      T_REG:   b = A_REG;
      T_DIR:   b = A_DIR;
      T_IND:   b = A_IND;
      default: b = 3'b000;
    endcase
    return b;
  endfunction

  function automatic logic types_ok(input op_desc_t d, input logic [7:0] enc);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if ((2'(i) < d.count) && ((d.allow[i] & type_bit(type_of(enc, 2'(i)))) == 3'b000)) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  phase_t           cur_phase;
  op_desc_t         desc, new_desc;
  logic [1:0]       idx, pnext, nidx, t_new;
  logic [2:0]       left_dec;
  logic [1:0]       em_status, em_count;
  logic [7:0]       em_opcode;
  logic [3:0]       em_size;
  logic [2:0][1:0]  em_types;
  logic [2:0][31:0] em_vals;
  logic [2:0][1:0]  out_types;
  logic [2:0][31:0] out_vals;

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    enc_nxt   = enc_r;
    pidx_nxt  = pidx_r;
    left_nxt  = left_r;
    vals_nxt  = vals_r;
    types_nxt = types_r;
    bcnt_nxt  = bcnt_r;
    res_valid = 1'b0;
    em_status = ST_OK;
    em_opcode = {3'b000, held_r};
    em_count  = 2'd0;
    em_size   = bcnt_r;
    t_new     = T_NONE;
    cur_phase = restart ? PH_OPC : phase_r;
    desc      = op_desc(held_r);
    new_desc  = op_desc(data_byte[4:0]);
    idx       = (pidx_r == 2'd3) ? 2'd2 : pidx_r;
    pnext     = pidx_r + 2'd1;
    nidx      = (pnext == 2'd3) ? 2'd2 : pnext;
    left_dec  = (left_r != 3'd0) ? left_r - 3'd1 : 3'd0;
    if (accept) begin
      unique case (cur_phase)
        PH_ENC: begin
          enc_nxt  = data_byte;
          bcnt_nxt = bcnt_r + 4'd1;
          if (!types_ok(desc, data_byte)) begin
            res_valid = 1'b1;
            em_status = ST_BADTYPE;
            em_count  = desc.count;
            em_size   = bcnt_nxt;
            phase_nxt = PH_OPC;
          end else begin
            t_new        = type_of(data_byte, 2'd0);
            pidx_nxt     = 2'd0;
            types_nxt[0] = t_new;
            vals_nxt[0]  = 32'd0;
            left_nxt     = param_len(t_new, desc.small_dir);
            phase_nxt    = PH_PAR;
          end
        end
        PH_PAR: begin
          vals_nxt[idx] = {vals_r[idx][23:0], data_byte};
          bcnt_nxt      = bcnt_r + 4'd1;
          left_nxt      = left_dec;
          if (left_dec == 3'd0) begin
            pidx_nxt = pnext;
            if (pnext >= desc.count) begin
              res_valid = 1'b1;
              em_status = ST_OK;
              em_count  = desc.count;
              em_size   = bcnt_nxt;
              phase_nxt = PH_OPC;
            end else begin
              t_new           = type_of(enc_r, nidx);
              types_nxt[nidx] = t_new;
              vals_nxt[nidx]  = 32'd0;
              left_nxt        = param_len(t_new, desc.small_dir);
            end
          end
        end
        default: begin
          types_nxt = '0;
          vals_nxt  = '0;
          pidx_nxt  = 2'd0;
          left_nxt  = 3'd0;
          bcnt_nxt  = 4'd1;
          phase_nxt = PH_OPC;
          if (data_byte == 8'h00 || data_byte > OPC_MAX) begin
            res_valid = 1'b1;
            em_status = ST_UNKNOWN;
            em_opcode = data_byte;
            em_count  = 2'd0;
            em_size   = 4'd1;
          end else begin
            held_nxt = data_byte[4:0];
            if (new_desc.has_enc) begin
              phase_nxt = PH_ENC;
            end else begin
              enc_nxt      = ENC_IMPLIED;
              types_nxt[0] = T_DIR;
              left_nxt     = param_len(T_DIR, new_desc.small_dir);
              phase_nxt    = PH_PAR;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    if (em_status == ST_BADTYPE) begin
      for (int i = 0; i < 3; i++) begin
        em_types[i] = type_of(enc_nxt, 2'(i));
      end
      em_vals = '0;
    end else begin
      em_types = types_nxt;
      em_vals  = vals_nxt;
    end
    for (int i = 0; i < 3; i++) begin
      out_types[i] = (2'(i) < em_count) ? em_types[i] : T_NONE;
      out_vals[i]  = (2'(i) < em_count) ? em_vals[i] : 32'd0;
    end
    res.status      = em_status;
    res.opcode      = em_opcode;
    res.param_count = em_count;
    res.type_a      = out_types[0];
    res.type_b      = out_types[1];
    res.type_c      = out_types[2];
    res.value_a     = $signed(out_vals[0]);
    res.value_b     = $signed(out_vals[1]);
    res.value_c     = $signed(out_vals[2]);
    res.size        = em_size;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPC;
      held_r  <= 5'd0;
      enc_r   <= 8'd0;
      pidx_r  <= 2'd0;
      left_r  <= 3'd0;
      vals_r  <= '0;
      types_r <= '0;
      bcnt_r  <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      enc_r   <= enc_nxt;
      pidx_r  <= pidx_nxt;
      left_r  <= left_nxt;
      vals_r  <= vals_nxt;
      types_r <= types_nxt;
      bcnt_r  <= bcnt_nxt;
    end
  end

endmodule

`default_nettype wire
